// ===== rtl/core/dcp_pkg.sv =====
// Shared constants and controller/datapath interface types for the divisor count block.
`default_nettype none

package dcp_pkg;

  localparam int ValueW      = 14;     // input integer width
  localparam int CntW        = 8;      // exponent counter width
  localparam int ModW        = 8;      // modulus and result width
  localparam int DivW        = 16;     // divider dividend and quotient width
  localparam int DvsW        = 8;      // divider divisor and remainder width
  localparam int TrialW      = 8;      // trial divisor width, holds up to 128
  localparam int ExpW        = 4;      // per-prime exponent within one integer
  localparam int MaxValueDef = 16384;  // histogram depth

  localparam logic [ModW-1:0] ModResetVal = 8'd10;

  // APB register map, selected by paddr[2]
  localparam int  ApbAddrW          = 3;
  localparam logic RegResultModulus = 1'b0;

  typedef struct packed {
    logic in_ready;   // accept an input transaction
    logic clr;        // clearing pass: zero entry at index, advance index
    logic div_start;  // load the divider
    logic div_sweep;  // divider operands from the product sweep
    logic x_upd;      // take quotient as new x, count one more factor
    logic d_inc;      // next trial divisor, clear factor count
    logic rmw_rd;     // read histogram at the prime
    logic rmw_wr;     // write saturated sum back at the prime
    logic sel_rem;    // prime is the leftover x rather than the trial divisor
    logic idx_clr;    // rewind the sweep index
    logic acc_init;   // seed the running product
    logic sw_rd;      // sweep: read and zero entry at index, advance index
    logic mul_ld;     // register running product times (count + 1)
    logic acc_upd;    // take divider remainder as running product
    logic out_ld;     // load the output register, drop the saturation flag
  } dcp_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic idx_last;   // index points at the last entry
    logic idx_end;    // index has passed the last entry
    logic dd_le_x;    // d * d <= x
    logic x_gt1;
    logic x_ok;       // x has a histogram bin
    logic d_ok;       // d has a histogram bin
    logic div_done;
    logic rem_zero;
    logic cnt_nz;
    logic rd_nz;      // histogram read data nonzero
    logic last;       // current item closes the set
    logic out_free;   // output register can take a result
  } dcp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/dcp_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module dcp_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [dcp_pkg::DivW-1:0]   dividend_i,
  input  wire logic [dcp_pkg::DvsW-1:0]   divisor_i,
  output logic                            done_o,
  output logic      [dcp_pkg::DivW-1:0]   quo_o,
  output logic      [dcp_pkg::DvsW-1:0]   rem_o
);

  localparam int StepW = $clog2(dcp_pkg::DivW + 1);

  logic                     busy_q;
  logic                     done_q;
  logic [StepW-1:0]         step_q;
  logic [dcp_pkg::DivW-1:0] quo_q;
  logic [dcp_pkg::DvsW-1:0] rem_q;
  logic [dcp_pkg::DvsW-1:0] dvs_q;

  logic [dcp_pkg::DvsW:0]   shifted;
  logic [dcp_pkg::DvsW+1:0] trial;

  assign shifted = {rem_q, quo_q[dcp_pkg::DivW-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= busy_q && (step_q == StepW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= StepW'(dcp_pkg::DivW);
      end else if (busy_q) begin
        step_q <= step_q - StepW'(1);
        if (step_q == StepW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      // keep the shifted remainder when the trial goes negative
      if (trial[dcp_pkg::DvsW+1]) begin
        rem_q <= shifted[dcp_pkg::DvsW-1:0];
        quo_q <= {quo_q[dcp_pkg::DivW-2:0], 1'b0};
      end else begin
        rem_q <= trial[dcp_pkg::DvsW-1:0];
        quo_q <= {quo_q[dcp_pkg::DivW-2:0], 1'b1};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> rem_q < dvs_q)
    else $error("divider remainder not below divisor");

  a_no_restart_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

endmodule

`default_nettype wire

// ===== rtl/core/dcp_datapath.sv =====
// Datapath: trial division registers, exponent histogram, product sweep, output register.
`default_nettype none

module dcp_datapath #(
  parameter int MaxValue = dcp_pkg::MaxValueDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire dcp_pkg::dcp_cmd_t            cmd_i,
  output dcp_pkg::dcp_sts_t                 sts_o,
  input  wire logic                         in_valid_i,
  input  wire logic [dcp_pkg::ValueW-1:0]   in_value_i,
  input  wire logic                         in_last_i,
  input  wire logic [dcp_pkg::ModW-1:0]     modulus_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [dcp_pkg::ModW-1:0]     out_count_o,
  output logic                              out_sat_o
);

  localparam int AddrW = $clog2(MaxValue);
  localparam int IdxW  = $clog2(MaxValue + 1);

  // factoring registers
  logic [dcp_pkg::ValueW-1:0] x_q;
  logic [dcp_pkg::TrialW-1:0] d_q;
  logic [dcp_pkg::ExpW-1:0]   cnt_q;
  logic                       last_q;

  // sweep registers
  logic [IdxW-1:0]            idx_q;
  logic [dcp_pkg::ModW-1:0]   acc_q;
  logic [dcp_pkg::DivW-1:0]   prod_q;

  logic                       sat_q;
  logic                       out_valid_q;
  logic [dcp_pkg::ModW-1:0]   out_count_q;
  logic                       out_sat_q;

  logic [dcp_pkg::CntW-1:0]   hist_q [MaxValue];
  logic [dcp_pkg::CntW-1:0]   rd_q;

  logic                       accept;
  logic [dcp_pkg::ModW-1:0]   m_eff;
  logic [2*dcp_pkg::TrialW-1:0] dd;
  logic [dcp_pkg::ValueW-1:0] prime;
  logic [AddrW-1:0]           prime_a;
  logic [AddrW-1:0]           idx_a;
  logic [dcp_pkg::ExpW-1:0]   amount;
  logic [dcp_pkg::CntW:0]     sum;
  logic [dcp_pkg::CntW-1:0]   sat_val;
  logic [dcp_pkg::CntW:0]     rd_inc;
  logic [dcp_pkg::DivW:0]     prod_full;

  logic                       mem_we;
  logic                       mem_re;
  logic [AddrW-1:0]           mem_waddr;
  logic [AddrW-1:0]           mem_raddr;
  logic [dcp_pkg::CntW-1:0]   mem_wdata;

  logic                       div_done;
  logic [dcp_pkg::DivW-1:0]   div_quo;
  logic [dcp_pkg::DvsW-1:0]   div_rem;
  logic [dcp_pkg::DivW-1:0]   div_dividend;
  logic [dcp_pkg::DvsW-1:0]   div_divisor;

  assign accept = cmd_i.in_ready && in_valid_i;
  // modulus zero behaves as modulus one
  assign m_eff  = (modulus_i == '0) ? dcp_pkg::ModW'(1) : modulus_i;
  assign dd     = (2*dcp_pkg::TrialW)'(d_q) * (2*dcp_pkg::TrialW)'(d_q);

  assign prime   = cmd_i.sel_rem ? x_q : dcp_pkg::ValueW'(d_q);
  assign prime_a = AddrW'(prime);
  assign idx_a   = idx_q[AddrW-1:0];
  assign amount  = cmd_i.sel_rem ? dcp_pkg::ExpW'(1) : cnt_q;
  assign sum     = {1'b0, rd_q} + (dcp_pkg::CntW+1)'(amount);
  assign sat_val = sum[dcp_pkg::CntW] ? '1 : sum[dcp_pkg::CntW-1:0];

  assign rd_inc    = {1'b0, rd_q} + (dcp_pkg::CntW+1)'(1);
  assign prod_full = (dcp_pkg::DivW+1)'(acc_q) * (dcp_pkg::DivW+1)'(rd_inc);

  assign div_dividend = cmd_i.div_sweep ? prod_q : dcp_pkg::DivW'(x_q);
  assign div_divisor  = cmd_i.div_sweep ? m_eff  : dcp_pkg::DvsW'(d_q);

  dcp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  // one write port, one read port; the sweep zeroes each entry as it reads it
  assign mem_we    = cmd_i.rmw_wr || cmd_i.sw_rd || cmd_i.clr;
  assign mem_re    = cmd_i.rmw_rd || cmd_i.sw_rd;
  assign mem_waddr = cmd_i.rmw_wr ? prime_a : idx_a;
  assign mem_raddr = cmd_i.rmw_rd ? prime_a : idx_a;
  assign mem_wdata = cmd_i.rmw_wr ? sat_val : '0;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= hist_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q    <= in_value_i;
      last_q <= in_last_i;
      d_q    <= dcp_pkg::TrialW'(2);
      cnt_q  <= '0;
    end else begin
      if (cmd_i.x_upd) begin
        x_q   <= div_quo[dcp_pkg::ValueW-1:0];
        cnt_q <= cnt_q + dcp_pkg::ExpW'(1);
      end
      if (cmd_i.d_inc) begin
        d_q   <= d_q + dcp_pkg::TrialW'(1);
        cnt_q <= '0;
      end
    end
    if (cmd_i.acc_init) begin
      acc_q <= (m_eff == dcp_pkg::ModW'(1)) ? '0 : dcp_pkg::ModW'(1);
    end else if (cmd_i.acc_upd) begin
      acc_q <= div_rem;
    end
    if (cmd_i.mul_ld) begin
      prod_q <= prod_full[dcp_pkg::DivW-1:0];
    end
    if (cmd_i.out_ld) begin
      out_count_q <= acc_q;
      out_sat_q   <= sat_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.clr || cmd_i.sw_rd) begin
        idx_q <= idx_q + IdxW'(1);
      end
      if (cmd_i.out_ld) begin
        sat_q <= 1'b0;
      end else if (cmd_i.rmw_wr && sum[dcp_pkg::CntW]) begin
        sat_q <= 1'b1;
      end
      if (cmd_i.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o          = '0;
    sts_o.in_valid = in_valid_i;
    sts_o.idx_last = (idx_q == IdxW'(MaxValue - 1));
    sts_o.idx_end  = (idx_q == IdxW'(MaxValue));
    sts_o.dd_le_x  = (dd <= (2*dcp_pkg::TrialW)'(x_q));
    sts_o.x_gt1    = (x_q > dcp_pkg::ValueW'(1));
    sts_o.x_ok     = (32'(x_q) < MaxValue);
    sts_o.d_ok     = (32'(d_q) < MaxValue);
    sts_o.div_done = div_done;
    sts_o.rem_zero = (div_rem == '0);
    sts_o.cnt_nz   = (cnt_q != '0);
    sts_o.rd_nz    = (rd_q != '0);
    sts_o.last     = last_q;
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_count_o = out_count_q;
  assign out_sat_o   = out_sat_q;

  a_acc_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mul_ld |-> acc_q < m_eff)
    else $error("running product not reduced before multiply");

  a_prime_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rmw_wr |-> 32'(prime) < MaxValue)
    else $error("histogram update outside its bins");

  a_sat_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_ld |=> !sat_q)
    else $error("saturation flag survived the end of a set");

endmodule

`default_nettype wire

// ===== rtl/core/dcp_ctrl.sv =====
// Controller: sequences clearing, trial division, histogram updates and the product sweep.
`default_nettype none

module dcp_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dcp_pkg::dcp_sts_t sts_i,
  output dcp_pkg::dcp_cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_TEST,
    ST_DWAIT,
    ST_DRE,
    ST_INC,
    ST_RD,
    ST_WR,
    ST_END,
    ST_SWR,
    ST_CHK,
    ST_MUL,
    ST_SDW,
    ST_SADV,
    ST_OUT
  } state_e;

  state_e            state_q;
  state_e            state_d;
  dcp_pkg::dcp_cmd_t cmd_q;
  dcp_pkg::dcp_cmd_t cmd_d;

  always_comb begin
    state_d = state_q;
    cmd_d   = '0;
    unique case (state_q)
      ST_CLR: begin
        if (sts_i.idx_last) begin
          state_d        = ST_IDLE;
          cmd_d.in_ready = 1'b1;
        end else begin
          cmd_d.clr = 1'b1;
        end
      end
      ST_IDLE: begin
        if (sts_i.in_valid) begin
          state_d = ST_TEST;
        end else begin
          cmd_d.in_ready = 1'b1;
        end
      end
      ST_TEST: begin
        priority if (sts_i.dd_le_x) begin
          state_d         = ST_DWAIT;
          cmd_d.div_start = 1'b1;
        end else if (sts_i.x_gt1 && sts_i.x_ok) begin
          // leftover factor above one is a prime
          state_d       = ST_RD;
          cmd_d.rmw_rd  = 1'b1;
          cmd_d.sel_rem = 1'b1;
        end else begin
          state_d        = ST_END;
          cmd_d.idx_clr  = 1'b1;
          cmd_d.acc_init = 1'b1;
        end
      end
      ST_DWAIT: begin
        if (sts_i.div_done) begin
          priority if (sts_i.rem_zero) begin
            state_d     = ST_DRE;
            cmd_d.x_upd = 1'b1;
          end else if (sts_i.cnt_nz && sts_i.d_ok) begin
            state_d      = ST_RD;
            cmd_d.rmw_rd = 1'b1;
          end else begin
            state_d     = ST_INC;
            cmd_d.d_inc = 1'b1;
          end
        end
      end
      ST_DRE: begin
        state_d         = ST_DWAIT;
        cmd_d.div_start = 1'b1;
      end
      ST_INC: begin
        state_d = ST_TEST;
      end
      ST_RD: begin
        state_d       = ST_WR;
        cmd_d.rmw_wr  = 1'b1;
        cmd_d.sel_rem = cmd_q.sel_rem;
      end
      ST_WR: begin
        if (cmd_q.sel_rem) begin
          state_d        = ST_END;
          cmd_d.idx_clr  = 1'b1;
          cmd_d.acc_init = 1'b1;
        end else begin
          state_d     = ST_INC;
          cmd_d.d_inc = 1'b1;
        end
      end
      ST_END: begin
        if (sts_i.last) begin
          state_d     = ST_SWR;
          cmd_d.sw_rd = 1'b1;
        end else begin
          state_d        = ST_IDLE;
          cmd_d.in_ready = 1'b1;
        end
      end
      ST_SWR: begin
        state_d = ST_CHK;
      end
      ST_CHK: begin
        priority if (sts_i.rd_nz) begin
          state_d      = ST_MUL;
          cmd_d.mul_ld = 1'b1;
        end else if (sts_i.idx_end) begin
          state_d = ST_OUT;
        end else begin
          state_d     = ST_SWR;
          cmd_d.sw_rd = 1'b1;
        end
      end
      ST_MUL: begin
        state_d         = ST_SDW;
        cmd_d.div_start = 1'b1;
        cmd_d.div_sweep = 1'b1;
      end
      ST_SDW: begin
        if (sts_i.div_done) begin
          state_d       = ST_SADV;
          cmd_d.acc_upd = 1'b1;
        end
      end
      ST_SADV: begin
        if (sts_i.idx_end) begin
          state_d = ST_OUT;
        end else begin
          state_d     = ST_SWR;
          cmd_d.sw_rd = 1'b1;
        end
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          state_d        = ST_IDLE;
          cmd_d.out_ld   = 1'b1;
          cmd_d.in_ready = 1'b1;
        end
      end
      default: begin
        state_d        = ST_IDLE;
        cmd_d.in_ready = 1'b1;
      end
    endcase
  end

  // commands are registered: each one acts during the cycle after it is set
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      cmd_q   <= '{clr: 1'b1, default: 1'b0};
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
    end
  end

  assign cmd_o = cmd_q;

  a_wr_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_q.rmw_wr |-> $past(cmd_q.rmw_rd))
    else $error("histogram write without a preceding read");

  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_q.in_ready |-> state_q == ST_IDLE)
    else $error("input ready outside idle");

endmodule

`default_nettype wire

// ===== rtl/core/divisor_count_of_product.sv =====
// Top level: stream ports, APB modulus register, controller and datapath.
//
// Each input integer is factored by trial division with d = 2, 3, ... while d*d <= x, on a
// shared 16-step restoring divider. Prime exponents go into a histogram memory of MaxValue
// 8-bit entries by read-modify-write (saturating at 255, which sets tuser). The item with
// tlast closes the set: the block then sweeps the whole histogram, zeroing it as it goes,
// multiplying (exponent + 1) and reducing modulo result_modulus (0 acts as 1) through the
// same divider. After reset a clearing pass over the histogram runs before the first item
// is taken. A finished result waits in the output register while the next item is already
// being factored.
`default_nettype none

module divisor_count_of_product #(
  parameter int MaxValue = dcp_pkg::MaxValueDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [15:0]                    s_axis_tdata,   // [13:0] value
  input  wire logic                           s_axis_tlast,   // last_item
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic      [7:0]                     m_axis_tdata,   // [7:0] divisor_count_mod
  output logic                                m_axis_tuser,   // [0] exponent_saturated
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [dcp_pkg::ApbAddrW-1:0]   paddr,
  input  wire logic [31:0]                    pwdata,
  output logic      [31:0]                    prdata,
  output logic                                pready
);

  logic [dcp_pkg::ModW-1:0] mod_q;
  dcp_pkg::dcp_cmd_t        cmd;
  dcp_pkg::dcp_sts_t        sts;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= dcp_pkg::ModResetVal;
    end else if (psel && penable && pwrite && pready
                 && (paddr[2] == dcp_pkg::RegResultModulus)) begin
      mod_q <= pwdata[dcp_pkg::ModW-1:0];
    end
  end

  assign prdata = (paddr[2] == dcp_pkg::RegResultModulus) ? 32'(mod_q) : '0;

  dcp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  dcp_datapath #(
    .MaxValue (MaxValue)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_valid_i  (s_axis_tvalid),
    .in_value_i  (s_axis_tdata[dcp_pkg::ValueW-1:0]),
    .in_last_i   (s_axis_tlast),
    .modulus_i   (mod_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_count_o (m_axis_tdata),
    .out_sat_o   (m_axis_tuser)
  );

  assign s_axis_tready = cmd.in_ready;

endmodule

`default_nettype wire

// ===== bench/divisor_count_of_product_check.sv =====
`timescale 1ns / 1ps
// Checker: watches the stream and APB ports, predicts each set's divisor count and compares.
module divisor_count_of_product_check (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,   // [13:0] value
  input  logic                          s_axis_tlast,   // last_item
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [7:0]                    m_axis_tdata,   // [7:0] divisor_count_mod
  input  logic                          m_axis_tuser,   // [0] exponent_saturated
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dcp_pkg::ApbAddrW-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  input  logic                          pready,
  output int                            fail_count,
  output int                            pending
);

  localparam int unsigned CntMax = (1 << dcp_pkg::CntW) - 1;

  typedef struct packed {
    logic [dcp_pkg::ModW-1:0] count_mod;
    logic                     saturated;
  } count_result_t;

  logic [dcp_pkg::CntW-1:0] exp_hist [dcp_pkg::MaxValueDef];
  logic                     sat_seen;
  logic [dcp_pkg::ModW-1:0] modulus;
  count_result_t            count_queue [$];
  count_result_t            want;

  function automatic void tally_prime(input int unsigned p, input int unsigned n);
    int unsigned sum;
    if (n == 0 || p >= dcp_pkg::MaxValueDef) return;
    sum = exp_hist[p] + n;
    if (sum > CntMax) begin
      sum = CntMax;
      sat_seen = 1'b1;
    end
    exp_hist[p] = sum[dcp_pkg::CntW-1:0];
  endfunction

  function automatic void factor_into_hist(input int unsigned x);
    int unsigned d;
    int unsigned n;
    if (x < 2) return;
    for (d = 2; d * d <= x; d++) begin
      n = 0;
      while (x % d == 0) begin
        x = x / d;
        n++;
      end
      tally_prime(d, n);
    end
    // leftover above one is itself prime
    if (x > 1) tally_prime(x, 1);
  endfunction

  function automatic count_result_t close_set();
    count_result_t r;
    int unsigned   m;
    int unsigned   acc;
    m   = (modulus == 0) ? 1 : modulus;
    acc = 1 % m;
    for (int i = 2; i < dcp_pkg::MaxValueDef; i++) begin
      if (exp_hist[i] != 0) acc = (acc * (exp_hist[i] + 1)) % m;
    end
    r.count_mod = acc[dcp_pkg::ModW-1:0];
    r.saturated = sat_seen;
    foreach (exp_hist[i]) exp_hist[i] = '0;
    sat_seen = 1'b0;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (exp_hist[i]) exp_hist[i] = '0;
      sat_seen   = 1'b0;
      modulus    = dcp_pkg::ModResetVal;
      count_queue.delete();
      pending    = 0;
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == dcp_pkg::RegResultModulus) begin
        modulus = pwdata[dcp_pkg::ModW-1:0];
      end
      if (s_axis_tvalid && s_axis_tready) begin
        factor_into_hist(s_axis_tdata[dcp_pkg::ValueW-1:0]);
        if (s_axis_tlast) count_queue.insert(count_queue.size(), close_set());
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (count_queue.size() == 0) begin
          $error("unexpected result transaction: divisor_count_mod %0d exponent_saturated %0d",
                 m_axis_tdata, m_axis_tuser);
          fail_count++;
        end else begin
          want = count_queue.pop_front();
          if (m_axis_tdata !== want.count_mod) begin
            $error("divisor_count_mod: expected %0d, actual %0d", want.count_mod, m_axis_tdata);
            fail_count++;
          end
          if (m_axis_tuser !== want.saturated) begin
            $error("exponent_saturated: expected %0d, actual %0d", want.saturated, m_axis_tuser);
            fail_count++;
          end
        end
      end
      pending = count_queue.size();
    end
  end

endmodule

// ===== bench/divisor_count_of_product_test.sv =====
`timescale 1ns / 1ps
// Testbench top: clock, reset, set stimulus, modulus writes, output stalls and the verdict.
module divisor_count_of_product_test;

  localparam int IdlePct      = 30;
  localparam int ItemTarget   = 450;
  localparam int ResultTarget = 30;
  localparam int LimitCycles  = 20_000_000;

  typedef enum int {SetSmall, SetWide, SetPower, SetSingle} set_kind_e;

  logic                         clk;
  logic                         rst_n    = 1'b0;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [15:0]                  s_tdata  = '0;
  logic                         s_tlast  = 1'b0;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [7:0]                   m_tdata;
  logic                         m_tuser;
  logic                         psel     = 1'b0;
  logic                         penable  = 1'b0;
  logic                         pwrite   = 1'b0;
  logic [dcp_pkg::ApbAddrW-1:0] paddr    = '0;
  logic [31:0]                  pwdata   = '0;
  logic [31:0]                  prdata;
  logic                         pready;

  int fails;
  int pending;
  bit quiet       = 1'b0;
  int items_sent  = 0;
  int sets_closed = 0;
  int cycles      = 0;

  divisor_count_of_product DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tlast (s_tlast),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata),
    .m_axis_tuser (m_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  divisor_count_of_product_check u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tlast (s_tlast),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata),
    .m_axis_tuser (m_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count   (fails),
    .pending      (pending)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    if (!rst_n) m_tready <= 1'b0;
    else m_tready <= quiet || ($urandom_range(99) >= IdlePct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LimitCycles) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_value(input logic [dcp_pkg::ValueW-1:0] v, input logic last);
    int gap;
    gap = (!quiet && $urandom_range(99) < IdlePct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(16-dcp_pkg::ValueW){1'b0}}, v};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    if (last) sets_closed++;
  endtask

  // Hold the input side until every pending result has been taken.
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_modulus(input logic [dcp_pkg::ModW-1:0] m);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {dcp_pkg::RegResultModulus, 2'b00};
    pwdata  <= {{(32-dcp_pkg::ModW){1'b0}}, m};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_set(input set_kind_e kind);
    int                         len;
    logic [dcp_pkg::ValueW-1:0] v;
    case (kind)
      SetSmall: len = $urandom_range(1, 20);
      SetWide:  len = $urandom_range(1, 8);
      SetPower: len = $urandom_range(16, 24);
      default:  len = 1;
    endcase
    for (int k = 0; k < len; k++) begin
      case (kind)
        SetSmall: v = dcp_pkg::ValueW'($urandom_range(0, 1023));
        // mostly 2^13, so long runs push the exponent of 2 past the counter limit
        SetPower: v = ($urandom_range(9) < 8) ? 14'd8192 :
                      ($urandom_range(1) ? 14'd4096 :
                       dcp_pkg::ValueW'($urandom_range(0, 255)));
        default:  v = dcp_pkg::ValueW'($urandom_range(0, (1 << dcp_pkg::ValueW) - 1));
      endcase
      send_value(v, k == len - 1);
    end
  endtask

  initial begin
    int                       phase;
    int                       nsets;
    int                       r;
    set_kind_e                kind;
    logic [dcp_pkg::ModW-1:0] mod;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset modulus: zero, one, smallest and largest values, the largest prime
    send_value(14'd0, 1'b1);
    send_value(14'd1, 1'b1);
    send_value(14'd2, 1'b0);
    send_value(14'd3, 1'b0);
    send_value(14'd16383, 1'b1);
    send_value(14'd16381, 1'b1);
    send_value(14'd4096, 1'b0);
    send_value(14'd8192, 1'b1);
    send_value(14'd0, 1'b0);
    send_value(14'd1, 1'b0);
    send_value(14'd10922, 1'b0);
    send_value(14'd5461, 1'b1);
    send_value(14'd12, 1'b1);

    phase = 0;
    while (items_sent < ItemTarget || sets_closed < ResultTarget) begin
      settle();
      case (phase)
        0:       mod = 8'd255;
        1:       mod = 8'd0;
        2:       mod = 8'd1;
        3:       mod = 8'd2;
        default: mod = dcp_pkg::ModW'($urandom_range(0, 255));
      endcase
      write_modulus(mod);
      quiet = (phase == 4);
      nsets = $urandom_range(3, 6);
      for (int s = 0; s < nsets; s++) begin
        r = $urandom_range(99);
        if (r < 45) kind = SetSmall;
        else if (r < 65) kind = SetWide;
        else if (r < 85) kind = SetPower;
        else kind = SetSingle;
        send_set(kind);
      end
      phase++;
    end

    quiet = 1'b0;
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (200) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/dcp_pkg.sv
rtl/core/dcp_div.sv
rtl/core/dcp_datapath.sv
rtl/core/dcp_ctrl.sv
rtl/core/divisor_count_of_product.sv
bench/divisor_count_of_product_check.sv
bench/divisor_count_of_product_test.sv
